### rtl/priority_inheritance_scheduler_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef PRIORITY_INHERITANCE_SCHEDULER_DEFINES_SVH
`define PRIORITY_INHERITANCE_SCHEDULER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PIS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define PIS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

### rtl/pis_pkg.sv
// Types, constants and helpers of the priority inheritance scheduler.
package pis_pkg;

   localparam int NUM_TASKS    = 64;
   localparam int PRIO_BITS    = 8;
   localparam int ID_BITS      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int ORDER_BITS   = 32;
   localparam int TASK_ID_BITS = 6;
   localparam int FIELD_PRIO_BITS = 8;

   typedef logic [PRIO_BITS-1:0]    prio_type;
   typedef logic [ID_BITS-1:0]      id_type;
   typedef logic [ORDER_BITS-1:0]   order_type;
   typedef logic [TASK_ID_BITS-1:0] task_id_type;

   localparam id_type LAST_ID = id_type'(NUM_TASKS - 1);

   typedef enum logic [1:0] {
      CMD_READY    = 2'd0,
      CMD_REMOVE   = 2'd1,
      CMD_SET_PRIO = 2'd2,
      CMD_RESCHED  = 2'd3
   } pis_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } pis_state_type;

   // One task record as held by a cell.
   typedef struct packed {
      logic      ready;
      prio_type  base;
      prio_type  inh;
      order_type order;
   } pis_rec_type;

   // Per-cell control plus the shared write data.
   typedef struct packed {
      logic      shift;
      logic      set_ready;
      logic      clr_ready;
      logic      set_prio;
      order_type order;
      prio_type  base;
      prio_type  inh;
   } pis_cell_ctl_type;

   // Result of the scan kept by the picker.
   typedef struct packed {
      logic     found;
      id_type   best_id;
      prio_type best_eff;
      prio_type run_eff;
   } pis_pick_type;

   // Inherited priority wins when nonzero.
   function automatic prio_type eff_prio(pis_rec_type rec);
      return (rec.inh != '0) ? rec.inh : rec.base;
   endfunction

endpackage

### rtl/pis_req_if.sv
// Command channel of the scheduler.
interface pis_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               cmd;
   pis_pkg::task_id_type     task_id;
   logic [pis_pkg::FIELD_PRIO_BITS-1:0] base_priority;
   logic [pis_pkg::FIELD_PRIO_BITS-1:0] inherited_priority;
   logic                     current_still_running;

   modport source (output valid, cmd, task_id, base_priority, inherited_priority,
                   current_still_running, input ready);
   modport sink   (input valid, cmd, task_id, base_priority, inherited_priority,
                   current_still_running, output ready);
endinterface

### rtl/pis_rsp_if.sv
// Result channel of the scheduler.
interface pis_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 switched;
   pis_pkg::task_id_type running_task;
   logic                 status;

   modport source (output valid, switched, running_task, status, input ready);
   modport sink   (input valid, switched, running_task, status, output ready);
endinterface

### rtl/pis_cell.sv
// One task slot of the rotating record chain.
module pis_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  pis_pkg::pis_cell_ctl_type ctl,
   input  pis_pkg::pis_rec_type      nbr_rec,
   output pis_pkg::pis_rec_type      rec
);

   pis_pkg::pis_rec_type rec_ff;
   pis_pkg::pis_rec_type rec_in;

   // Rotate during a scan, otherwise apply the slot writes.
   always_comb begin
      rec_in = rec_ff;
      if (ctl.shift) begin
         rec_in = nbr_rec;
      end else begin
         if (ctl.set_ready) begin
            rec_in.ready = 1'b1;
            rec_in.order = ctl.order;
         end
         if (ctl.clr_ready) begin
            rec_in.ready = 1'b0;
         end
         if (ctl.set_prio) begin
            rec_in.base = ctl.base;
            rec_in.inh  = ctl.inh;
         end
      end
   end

   // Hold ready mark and priorities, cleared by reset; the insertion number
   // is valid only once the slot was made ready.
   always_ff @(posedge clock) begin
      rec_ff.order <= rec_in.order;
      if (reset) begin
         rec_ff.ready <= 1'b0;
         rec_ff.base  <= '0;
         rec_ff.inh   <= '0;
      end else begin
         rec_ff.ready <= rec_in.ready;
         rec_ff.base  <= rec_in.base;
         rec_ff.inh   <= rec_in.inh;
      end
   end

   assign rec = rec_ff;

endmodule

### rtl/pis_pick.sv
// Best-candidate tracker at the head of the cell chain.
module pis_pick (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  logic                  step,
   input  pis_pkg::pis_rec_type  cand,
   input  pis_pkg::id_type       cand_id,
   input  pis_pkg::id_type       running_id,
   output pis_pkg::pis_pick_type pick
);

   logic               found_ff, found_in;
   pis_pkg::id_type    best_id_ff, best_id_in;
   pis_pkg::prio_type  best_eff_ff, best_eff_in;
   pis_pkg::prio_type  best_base_ff, best_base_in;
   pis_pkg::order_type best_order_ff, best_order_in;
   pis_pkg::prio_type  run_eff_ff, run_eff_in;
   pis_pkg::prio_type  cand_eff;
   logic               eligible;
   logic               better;

   assign cand_eff = pis_pkg::eff_prio(cand);
   assign eligible = step && cand.ready && (cand_id != running_id);

   // Rank by effective priority, then base priority, then oldest insertion.
   always_comb begin
      if (!found_ff) begin
         better = 1'b1;
      end else if (cand_eff != best_eff_ff) begin
         better = cand_eff > best_eff_ff;
      end else if (cand.base != best_base_ff) begin
         better = cand.base > best_base_ff;
      end else begin
         better = cand.order < best_order_ff;
      end
   end

   // Update best record and capture the running task's priority on its turn.
   always_comb begin
      found_in      = found_ff;
      best_id_in    = best_id_ff;
      best_eff_in   = best_eff_ff;
      best_base_in  = best_base_ff;
      best_order_in = best_order_ff;
      run_eff_in    = run_eff_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (eligible && better) begin
         found_in      = 1'b1;
         best_id_in    = cand_id;
         best_eff_in   = cand_eff;
         best_base_in  = cand.base;
         best_order_in = cand.order;
      end
      if (step && (cand_id == running_id)) begin
         run_eff_in = cand_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_id_ff    <= best_id_in;
      best_eff_ff   <= best_eff_in;
      best_base_ff  <= best_base_in;
      best_order_ff <= best_order_in;
      run_eff_ff    <= run_eff_in;
   end

   assign pick = '{found: found_ff, best_id: best_id_ff, best_eff: best_eff_ff,
                   run_eff: run_eff_ff};

endmodule

### rtl/priority_inheritance_scheduler.sv
// Priority inheritance task scheduler: make ready, remove, set priorities and
// reschedule commands each return one result. Task records sit in a row of
// NUM_TASKS cells; a reschedule rotates the whole row once past a single
// comparator at cell 0 in the scan state, then commits in the finish state;
// no command is taken until it is back in idle. The other commands write their
// slot and load the result register when accepted. The next command is taken
// as soon as the result register is free or draining.
`include "priority_inheritance_scheduler_defines.svh"

module priority_inheritance_scheduler (
   input  logic     clock,
   input  logic     reset,
   pis_req_if.sink  req_chan,
   pis_rsp_if.source rsp_chan
);

   pis_pkg::pis_state_type state_ff, state_in;
   pis_pkg::id_type        cnt_ff, cnt_in;
   logic                   still_ff, still_in;
   pis_pkg::id_type        running_id_ff, running_id_in;
   pis_pkg::order_type     counter_ff, counter_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_switched_ff, rsp_switched_in;
   pis_pkg::task_id_type   rsp_running_ff, rsp_running_in;
   logic                   rsp_status_ff, rsp_status_in;

   pis_pkg::pis_rec_type     cell_rec [pis_pkg::NUM_TASKS];
   pis_pkg::pis_cell_ctl_type cell_ctl [pis_pkg::NUM_TASKS];
   pis_pkg::pis_pick_type    pick;

   pis_pkg::pis_cmd_type cmd;
   logic                 accept;
   logic                 slot_free;
   logic                 in_ready;
   logic                 shift;
   logic                 step;
   logic                 tid_ok;
   pis_pkg::id_type      tid_idx;
   logic                 tid_ready;
   logic                 keep;
   logic                 fin_err;
   logic                 fin_switch;
   logic                 mark_new;

   assign cmd       = pis_pkg::pis_cmd_type'(req_chan.cmd);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign accept    = req_chan.valid && in_ready;
   assign tid_ok    = 32'(req_chan.task_id) < pis_pkg::NUM_TASKS;
   assign tid_idx   = pis_pkg::id_type'(req_chan.task_id);

   // Look up the ready mark of the addressed slot.
   always_comb begin
      tid_ready = 1'b0;
      for (int k = 0; k < pis_pkg::NUM_TASKS; k++) begin
         if (tid_idx == pis_pkg::id_type'(k)) begin
            tid_ready = cell_rec[k].ready;
         end
      end
   end

   // Decide the outcome of a reschedule at the end of the scan.
   assign keep       = still_ff && (!pick.found || (pick.best_eff < pick.run_eff));
   assign fin_err    = !keep && !pick.found;
   assign fin_switch = (state_ff == pis_pkg::ST_FINISH) && !keep && pick.found;
   assign mark_new   = (accept && (cmd == pis_pkg::CMD_READY) && tid_ok && !tid_ready)
                       || (fin_switch && still_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pis_pkg::ST_IDLE: begin
            if (accept && (cmd == pis_pkg::CMD_RESCHED)) begin
               state_in = pis_pkg::ST_SCAN;
            end
         end
         pis_pkg::ST_SCAN: begin
            if (cnt_ff == pis_pkg::LAST_ID) begin
               state_in = pis_pkg::ST_FINISH;
            end
         end
         pis_pkg::ST_FINISH: begin
            state_in = pis_pkg::ST_IDLE;
         end
         default: begin
            state_in = pis_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      in_ready = 1'b0;
      shift    = 1'b0;
      step     = 1'b0;
      case (state_ff)
         pis_pkg::ST_IDLE: begin
            in_ready = slot_free;
         end
         pis_pkg::ST_SCAN: begin
            shift = 1'b1;
            step  = 1'b1;
         end
         pis_pkg::ST_FINISH: begin
            in_ready = 1'b0;
         end
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

   // Drive per-cell writes from commands and from the commit of a switch.
   always_comb begin
      for (int k = 0; k < pis_pkg::NUM_TASKS; k++) begin
         cell_ctl[k].shift     = shift;
         cell_ctl[k].order     = counter_ff;
         cell_ctl[k].base      = pis_pkg::prio_type'(req_chan.base_priority);
         cell_ctl[k].inh       = pis_pkg::prio_type'(req_chan.inherited_priority);
         cell_ctl[k].set_ready = 1'b0;
         cell_ctl[k].clr_ready = 1'b0;
         cell_ctl[k].set_prio  = 1'b0;
         if (accept && tid_ok && (tid_idx == pis_pkg::id_type'(k))) begin
            case (cmd)
               pis_pkg::CMD_READY:    cell_ctl[k].set_ready = !cell_rec[k].ready;
               pis_pkg::CMD_REMOVE:   cell_ctl[k].clr_ready = 1'b1;
               pis_pkg::CMD_SET_PRIO: cell_ctl[k].set_prio  = 1'b1;
               default:               cell_ctl[k].set_prio  = 1'b0;
            endcase
         end
         if (fin_switch && still_ff && (running_id_ff == pis_pkg::id_type'(k))) begin
            cell_ctl[k].set_ready = 1'b1;
         end
         if (fin_switch && (pick.best_id == pis_pkg::id_type'(k))) begin
            cell_ctl[k].clr_ready = 1'b1;
         end
      end
   end

   // Row of task cells; each takes its upper neighbor's record while scanning.
   for (genvar k = 0; k < pis_pkg::NUM_TASKS; k++) begin : g_slot
      pis_cell u_slot (
         .clock   (clock),
         .reset   (reset),
         .ctl     (cell_ctl[k]),
         .nbr_rec (cell_rec[(k + 1) % pis_pkg::NUM_TASKS]),
         .rec     (cell_rec[k])
      );
   end

   // Compare the record passing cell 0 against the best so far.
   pis_pick u_pick (
      .clock      (clock),
      .reset      (reset),
      .clear      (accept),
      .step       (step),
      .cand       (cell_rec[0]),
      .cand_id    (cnt_ff),
      .running_id (running_id_ff),
      .pick       (pick)
   );

   // Advance the scan index, latch the runnable flag, track the running task and the insertion counter.
   always_comb begin
      cnt_in        = (state_ff == pis_pkg::ST_SCAN) ? cnt_ff + 1'b1 : '0;
      still_in      = accept ? req_chan.current_still_running : still_ff;
      running_id_in = fin_switch ? pick.best_id : running_id_ff;
      counter_in    = mark_new ? counter_ff + 1'b1 : counter_ff;
   end

   // Load the result register on a simple command or at commit; drop on transfer.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_switched_in = rsp_switched_ff;
      rsp_running_in  = rsp_running_ff;
      rsp_status_in   = rsp_status_ff;
      if (accept && (cmd != pis_pkg::CMD_RESCHED)) begin
         rsp_valid_in    = 1'b1;
         rsp_switched_in = 1'b0;
         rsp_running_in  = pis_pkg::task_id_type'(running_id_ff);
         rsp_status_in   = 1'b0;
      end else if (state_ff == pis_pkg::ST_FINISH) begin
         rsp_valid_in    = 1'b1;
         rsp_switched_in = fin_switch;
         rsp_running_in  = pis_pkg::task_id_type'(running_id_in);
         rsp_status_in   = fin_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pis_pkg::ST_IDLE;
         cnt_ff        <= '0;
         still_ff      <= 1'b0;
         running_id_ff <= '0;
         counter_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         still_ff      <= still_in;
         running_id_ff <= running_id_in;
         counter_ff    <= counter_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_switched_ff <= rsp_switched_in;
      rsp_running_ff  <= rsp_running_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign req_chan.ready        = in_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.switched     = rsp_switched_ff;
   assign rsp_chan.running_task = rsp_running_ff;
   assign rsp_chan.status       = rsp_status_ff;

   // No command transfer while a reschedule is in flight.
   `PIS_ASSERT_SAME(a_busy_no_accept, clock, reset, state_ff != pis_pkg::ST_IDLE, !(req_chan.valid && req_chan.ready))
   // The chosen task is never the running one.
   `PIS_ASSERT_SAME(a_best_not_running, clock, reset, (state_ff == pis_pkg::ST_FINISH) && pick.found, pick.best_id != running_id_ff)
   // A committed switch changes the running task.
   `PIS_ASSERT_NEXT(a_switch_moves, clock, reset, fin_switch, running_id_ff != $past(running_id_ff))

endmodule

### bench/priority_inheritance_scheduler_test.sv
// Self-checking testbench for the priority inheritance scheduler with a built-in predictor.
module priority_inheritance_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400_000;
   localparam int RANDOM_ITEMS  = 500;
   localparam int HOLD_AT       = 120;
   localparam int LONG_HOLD     = 600;
   localparam int SETTLE_CYCLES = 100;
   localparam int MAX_REPORTS   = 10;

   typedef logic [pis_pkg::FIELD_PRIO_BITS-1:0] field_prio_type;

   // One command as offered on the request channel
   typedef struct {
      pis_pkg::pis_cmd_type cmd;
      pis_pkg::task_id_type task_id;
      field_prio_type       base_priority;
      field_prio_type       inherited_priority;
      logic                 still;
      bit                   wait_drain;
   } sched_cmd_type;

   typedef struct packed {
      logic                 switched;
      pis_pkg::task_id_type running_task;
      logic                 status;
   } sched_outcome_type;

   logic clock;
   logic reset;

   pis_req_if req_chan();
   pis_rsp_if rsp_chan();

   priority_inheritance_scheduler u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted task table and running task
   logic               task_ready [pis_pkg::NUM_TASKS];
   pis_pkg::prio_type  task_base  [pis_pkg::NUM_TASKS];
   pis_pkg::prio_type  task_inh   [pis_pkg::NUM_TASKS];
   pis_pkg::order_type task_seq   [pis_pkg::NUM_TASKS];
   pis_pkg::order_type seq_next;
   pis_pkg::id_type    cur_task;

   sched_cmd_type     cmd_backlog[$];
   sched_outcome_type expected_outcomes[$];
   sched_cmd_type     on_offer;

   int accepted_count = 0;
   int total_items    = 0;
   int fail_count     = 0;
   int cycle_count    = 0;
   int send_gap       = 0;
   int send_calm      = 0;
   int stall_left     = 0;
   int sink_calm      = 0;
   bit long_hold_done = 0;

   function automatic pis_pkg::prio_type effective_prio(int t);
      return (task_inh[t] != '0) ? task_inh[t] : task_base[t];
   endfunction

   function automatic void enqueue_ready(int t);
      task_ready[t] = 1'b1;
      task_seq[t]   = seq_next;
      seq_next      = seq_next + 1;
   endfunction

   // Apply one command to the predicted table and return its result
   function automatic sched_outcome_type apply_command(sched_cmd_type c);
      sched_outcome_type res;
      logic found;
      logic better;
      logic keep;
      int   best;
      res   = '0;
      found = 1'b0;
      best  = 0;
      case (c.cmd)
         pis_pkg::CMD_READY: begin
            if (!task_ready[c.task_id]) enqueue_ready(c.task_id);
         end
         pis_pkg::CMD_REMOVE: begin
            task_ready[c.task_id] = 1'b0;
         end
         pis_pkg::CMD_SET_PRIO: begin
            task_base[c.task_id] = pis_pkg::prio_type'(c.base_priority);
            task_inh[c.task_id]  = pis_pkg::prio_type'(c.inherited_priority);
         end
         default: begin
            // scan ready slots, running task excluded
            for (int t = 0; t < pis_pkg::NUM_TASKS; t++) begin
               if (task_ready[t] && pis_pkg::id_type'(t) != cur_task) begin
                  if (!found)
                     better = 1'b1;
                  else if (effective_prio(t) != effective_prio(best))
                     better = effective_prio(t) > effective_prio(best);
                  else if (task_base[t] != task_base[best])
                     better = task_base[t] > task_base[best];
                  else
                     better = task_seq[t] < task_seq[best];
                  if (better) begin
                     best  = t;
                     found = 1'b1;
                  end
               end
            end
            keep = c.still && (!found || effective_prio(best) < effective_prio(cur_task));
            if (!keep) begin
               if (!found) begin
                  res.status = 1'b1;
               end else begin
                  if (c.still) enqueue_ready(cur_task);
                  task_ready[best] = 1'b0;
                  cur_task         = pis_pkg::id_type'(best);
                  res.switched     = 1'b1;
               end
            end
         end
      endcase
      res.running_task = pis_pkg::task_id_type'(cur_task);
      return res;
   endfunction

   function automatic sched_cmd_type build_cmd(pis_pkg::pis_cmd_type cmd, int id, int bp,
                                               int ip, bit still);
      sched_cmd_type c;
      c.cmd                = cmd;
      c.task_id            = pis_pkg::task_id_type'(id);
      c.base_priority      = field_prio_type'(bp);
      c.inherited_priority = field_prio_type'(ip);
      c.still              = still;
      c.wait_drain         = 1'b0;
      return c;
   endfunction

   function automatic sched_cmd_type noise_cmd();
      return build_cmd(pis_pkg::pis_cmd_type'($urandom_range(0, 3)),
                       $urandom_range(0, pis_pkg::NUM_TASKS - 1),
                       $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
   endfunction

   // Narrow priorities make ties on effective and base priority likely
   function automatic field_prio_type pick_prio(bit narrow);
      if (!narrow) return field_prio_type'($urandom_range(0, 255));
      if ($urandom_range(0, 9) < 8) return field_prio_type'($urandom_range(0, 3));
      return field_prio_type'($urandom_range(254, 255));
   endfunction

   // Mostly short pauses, a few long ones
   function automatic int draw_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 90);
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Drive the request channel from the backlog
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_outcomes.push_back(apply_command(on_offer));
            accepted_count++;
         end
         if (!(req_chan.valid && !req_chan.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].wait_drain && expected_outcomes.size() != 0)) begin
               on_offer = cmd_backlog.pop_front();
               req_chan.valid                 <= 1'b1;
               req_chan.cmd                   <= on_offer.cmd;
               req_chan.task_id               <= on_offer.task_id;
               req_chan.base_priority         <= on_offer.base_priority;
               req_chan.inherited_priority    <= on_offer.inherited_priority;
               req_chan.current_still_running <= on_offer.still;
               if (send_calm > 0) send_calm--;
               else if ($urandom_range(0, 49) == 0) send_calm = 40;
               else send_gap = draw_pause();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Stall the result channel, once for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!long_hold_done && accepted_count >= HOLD_AT) begin
         long_hold_done = 1'b1;
         stall_left     = LONG_HOLD - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (sink_calm > 0) sink_calm--;
         else if ($urandom_range(0, 49) == 0) sink_calm = 40;
         else if ($urandom_range(0, 3) == 0) stall_left = draw_pause();
      end
   end

   // Check each result transfer against the oldest prediction
   always @(posedge clock) begin
      sched_outcome_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_outcomes.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("unexpected result: switched %0b running_task %0d status %0b",
                        rsp_chan.switched, rsp_chan.running_task, rsp_chan.status);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_chan.switched !== want.switched ||
                rsp_chan.running_task !== want.running_task ||
                rsp_chan.status !== want.status) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("mismatch: expected switched %0b running_task %0d status %0b, %s",
                           want.switched, want.running_task, want.status,
                           $sformatf("got switched %0b running_task %0d status %0b",
                                     rsp_chan.switched, rsp_chan.running_task,
                                     rsp_chan.status));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("priority_inheritance_scheduler verification failed");
         $finish;
      end
   end

   initial begin
      int            made;
      int            span;
      int            lo;
      int            steps;
      int            pick;
      int            n;
      int            first_random;
      bit            narrow;
      sched_cmd_type item;

      reset                          = 1'b1;
      req_chan.valid                 = 1'b0;
      req_chan.cmd                   = pis_pkg::CMD_READY;
      req_chan.task_id               = '0;
      req_chan.base_priority         = '0;
      req_chan.inherited_priority    = '0;
      req_chan.current_still_running = 1'b0;
      rsp_chan.ready                 = 1'b0;

      for (int t = 0; t < pis_pkg::NUM_TASKS; t++) begin
         task_ready[t] = 1'b0;
         task_base[t]  = '0;
         task_inh[t]   = '0;
         task_seq[t]   = '0;
      end
      seq_next = '0;
      cur_task = '0;

      // Directed: empty set, extremes, ties, running task marked ready
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_RESCHED, 0, 0, 0, 1));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_RESCHED, 63, 255, 255, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_SET_PRIO, 63, 255, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_SET_PRIO, 1, 0, 255, 1));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_SET_PRIO, 2, 255, 255, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_READY, 63, 0, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_READY, 1, 255, 255, 1));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_READY, 2, 0, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_READY, 1, 0, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_RESCHED, 0, 0, 0, 1));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_RESCHED, 0, 0, 0, 1));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_REMOVE, 63, 0, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_REMOVE, 0, 0, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_READY, 2, 0, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_RESCHED, 0, 0, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_RESCHED, 0, 0, 0, 1));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_SET_PRIO, 1, 5, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_RESCHED, 0, 0, 0, 1));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_REMOVE, 1, 0, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_SET_PRIO, 3, 7, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_SET_PRIO, 4, 7, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_READY, 4, 0, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_READY, 3, 0, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_RESCHED, 0, 0, 0, 0));
      cmd_backlog.push_back(build_cmd(pis_pkg::CMD_RESCHED, 0, 0, 0, 0));
      first_random = cmd_backlog.size();

      // Random: short scheduling episodes on a pool of tasks, some noise
      made = 0;
      while (made < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               cmd_backlog.push_back(noise_cmd());
               made++;
            end
         end else begin
            pick = $urandom_range(0, 9);
            span = (pick < 7) ? $urandom_range(2, 8) : (pick < 9) ? 16 : pis_pkg::NUM_TASKS;
            lo     = $urandom_range(0, pis_pkg::NUM_TASKS - span);
            narrow = $urandom_range(0, 1);
            steps  = $urandom_range(6, 20);
            repeat (steps) begin
               item = noise_cmd();
               if ($urandom_range(0, 19) != 0)
                  item.task_id = pis_pkg::task_id_type'(lo + $urandom_range(0, span - 1));
               pick = $urandom_range(0, 99);
               if (pick < 25) begin
                  item.cmd                = pis_pkg::CMD_SET_PRIO;
                  item.base_priority      = pick_prio(narrow);
                  item.inherited_priority = $urandom_range(0, 1) ? '0 : pick_prio(narrow);
               end else if (pick < 55) begin
                  item.cmd = pis_pkg::CMD_READY;
               end else if (pick < 67) begin
                  item.cmd = pis_pkg::CMD_REMOVE;
               end else begin
                  item.cmd   = pis_pkg::CMD_RESCHED;
                  item.still = ($urandom_range(0, 9) < 7);
               end
               cmd_backlog.push_back(item);
               made++;
            end
         end
      end
      // Hold the sender until the block has drained
      cmd_backlog[first_random].wait_drain       = 1'b1;
      cmd_backlog[first_random + 300].wait_drain = 1'b1;
      total_items = cmd_backlog.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items) @(posedge clock);
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_outcomes.size() == 0)
         $display("priority_inheritance_scheduler verification clean");
      else
         $display("priority_inheritance_scheduler verification failed");
      $finish;
   end

endmodule

### priority_inheritance_scheduler.f
+incdir+rtl
rtl/pis_pkg.sv
rtl/pis_req_if.sv
rtl/pis_rsp_if.sv
rtl/pis_cell.sv
rtl/pis_pick.sv
rtl/priority_inheritance_scheduler.sv
bench/priority_inheritance_scheduler_test.sv
